// File: src/ddo_pkg.sv
package ddo_pkg;

  // Parameter defaults
  localparam int unsigned ANGLE_BITS_DEF   = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_MPP       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ASCALE    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CFG_AW-1:0] REG_START_X   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_START_Y   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_START_HD  = 3'd5;

  // Register reset values
  localparam logic [31:0] MPP_RST    = 32'd143926000;
  localparam logic [31:0] ASCALE_RST = 32'd427229184;
  localparam logic [30:0] THR_RST    = 31'd683565;

  // Fixed-point constants
  localparam logic [30:0] ONE_Q30         = 31'd1073741824;
  localparam logic [33:0] CORDIC_GAIN_INV = 34'd652032874;
  localparam logic [31:0] TWO32_OVER_PI   = 32'd1367130551;
  localparam logic [30:0] DT_MAX          = 31'h7FFF_FFFF;

  // atan(2^-i) as binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: src/differential_drive_odometry.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: left_count, right_count; tuser: rebase
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pos_x, pos_y, heading, distance
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_addr_i (register index), cfg_data_i
//
// An arc sample keeps the input busy from transfer to the next ready for longer than a
// straight sample: seven multiply ops, each through PREP, MLO, MHI and MFIN on the one
// shared 32x32 multiplier, CORDIC passes and a restoring divide for sinc (divide and
// half-angle pass skipped on the straight path). A rebase sample goes from IDLE straight
// to DONE. Reset clears pose, counts and loads the register defaults. The result register
// lets the next sample start while a result waits; the sequencer only stalls in its last
// state while that register is still full.
module differential_drive_odometry #(
  parameter int unsigned ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // left_count, right_count
  input  logic                        s_axis_tuser,   // rebase
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [143:0]                m_axis_tdata,   // pos_x, pos_y, heading, distance
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ddo_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [31:0]                 cfg_data_i
);

  import ddo_pkg::*;

  // binary-angle mask keeping the top ANGLE_BITS bits
  localparam logic [31:0] AngMask = ~(32'hFFFF_FFFF >> ANGLE_BITS);
  localparam logic [4:0]  CrdLast = 5'(CORDIC_STEPS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_MLO   = 4'd2;
  localparam logic [3:0] S_MHI   = 4'd3;
  localparam logic [3:0] S_MFIN  = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CITER = 4'd6;
  localparam logic [3:0] S_CDONE = 4'd7;
  localparam logic [3:0] S_NUM   = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DITER = 4'd10;
  localparam logic [3:0] S_DFIN  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // multiply ops
  localparam logic [2:0] OP_DL = 3'd0;
  localparam logic [2:0] OP_DR = 3'd1;
  localparam logic [2:0] OP_DT = 3'd2;
  localparam logic [2:0] OP_C  = 3'd3;
  localparam logic [2:0] OP_S  = 3'd4;
  localparam logic [2:0] OP_PX = 3'd5;
  localparam logic [2:0] OP_PY = 3'd6;

  logic [3:0]  state_q;
  logic [2:0]  op_q;

  // configuration
  logic [31:0] mpp_q, ascale_q;
  logic [30:0] thr_q;
  logic [31:0] start_x_q, start_y_q, start_hd_q;

  // odometry state
  logic [31:0]        prev_l_q, prev_r_q;
  logic signed [31:0] x_q, y_q, hd_q;
  logic signed [47:0] dist_q;

  // per-sample working registers
  logic [31:0]        dlt_l_q, dlt_r_q;
  logic signed [44:0] dl_q, dr_q, centre_q;
  logic signed [31:0] dt_q;
  logic [30:0]        adt_q, sinc_q;
  logic [31:0]        ang_q;
  logic               half_q;
  logic signed [33:0] c_q, s_q, c2_q, s2_q;

  // shared multiplier op
  logic [44:0] a_q;
  logic [31:0] b_q;
  logic        neg_q;
  logic [4:0]  sh_q;
  logic [63:0] prod_q, acc_q;

  // CORDIC
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [4:0]         ci_q;
  logic               flip_q;

  // divider
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [5:0]  dcnt_q;

  // result register
  logic         out_valid_q;
  logic [143:0] out_q;

  // combinational
  logic [31:0]        mul_a;
  logic [63:0]        mul_p, lo_part, acc_fin, res;
  logic [31:0]        abs_dlt_l, abs_dlt_r;
  logic signed [45:0] diff, csum;
  logic [44:0]        abs_diff, abs_centre;
  logic [31:0]        abs_c, abs_s, abs_c2, abs_s2;
  logic [30:0]        dt_mag;
  logic signed [31:0] dt_val;
  logic [31:0]        crd_a, crd_aw;
  logic signed [33:0] crd_z0, crd_zw;
  logic               crd_wrap;
  logic signed [33:0] cdx, cdy, catan, fx, fy;
  logic [32:0]        rem_ext, rem_sub;
  logic               div_ge;
  logic signed [46:0] xs, ys;
  logic signed [48:0] ds;
  logic signed [31:0] x_sat, y_sat;
  logic signed [47:0] d_sat;
  logic               in_acc, out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    // shared 32x32 multiplier: low word, then high bits of the 45-bit operand
    mul_a   = (state_q == S_MHI) ? 32'(a_q[44:32]) : a_q[31:0];
    mul_p   = 64'(mul_a) * 64'(b_q);
    lo_part = (prod_q + (64'd1 << (sh_q - 5'd1))) >> sh_q;
    acc_fin = acc_q + (prod_q << (6'd32 - {1'b0, sh_q}));
    res     = neg_q ? (64'd0 - acc_fin) : acc_fin;

    abs_dlt_l  = dlt_l_q[31] ? (32'd0 - dlt_l_q) : dlt_l_q;
    abs_dlt_r  = dlt_r_q[31] ? (32'd0 - dlt_r_q) : dlt_r_q;
    diff       = 46'(dr_q) - 46'(dl_q);
    csum       = 46'(dr_q) + 46'(dl_q);
    abs_diff   = diff[45] ? 45'(-diff) : diff[44:0];
    abs_centre = centre_q[44] ? 45'(-centre_q) : centre_q;
    abs_c      = c_q[33]  ? 32'(-c_q)  : c_q[31:0];
    abs_s      = s_q[33]  ? 32'(-s_q)  : s_q[31:0];
    abs_c2     = c2_q[33] ? 32'(-c2_q) : c2_q[31:0];
    abs_s2     = s2_q[33] ? 32'(-s2_q) : s2_q[31:0];

    // heading change, saturated
    dt_mag = (acc_fin > 64'(DT_MAX)) ? DT_MAX : acc_fin[30:0];
    dt_val = neg_q ? -$signed({1'b0, dt_mag}) : $signed({1'b0, dt_mag});

    // CORDIC input: fold to [-quarter, quarter] turn
    crd_a    = (half_q ? {2'b00, adt_q[30:1]} : ang_q) & AngMask;
    crd_aw   = crd_a + 32'h8000_0000;
    crd_z0   = 34'($signed(crd_a));
    crd_wrap = (crd_z0 > 34'sd1073741824) || (crd_z0 < -34'sd1073741824);
    crd_zw   = crd_wrap ? 34'($signed(crd_aw)) : crd_z0;
    cdx      = cy_q >>> ci_q;
    cdy      = cx_q >>> ci_q;
    catan    = $signed({2'b00, atan_lut(ci_q)});
    fx       = flip_q ? -cx_q : cx_q;
    fy       = flip_q ? -cy_q : cy_q;

    // restoring divide step
    rem_ext = {rem_q, quo_q[63]};
    div_ge  = rem_ext >= {2'b00, adt_q};
    rem_sub = rem_ext - {2'b00, adt_q};

    // saturating accumulators
    xs = 47'(x_q) + $signed(res[46:0]);
    ys = 47'(y_q) + $signed(res[46:0]);
    ds = 49'(dist_q) + 49'(centre_q);
    if (xs > 47'sd2147483647)       x_sat = 32'sh7FFF_FFFF;
    else if (xs < -47'sd2147483648) x_sat = 32'sh8000_0000;
    else                            x_sat = xs[31:0];
    if (ys > 47'sd2147483647)       y_sat = 32'sh7FFF_FFFF;
    else if (ys < -47'sd2147483648) y_sat = 32'sh8000_0000;
    else                            y_sat = ys[31:0];
    if (ds > 49'sd140737488355327)       d_sat = 48'sh7FFF_FFFF_FFFF;
    else if (ds < -49'sd140737488355328) d_sat = 48'sh8000_0000_0000;
    else                                 d_sat = ds[47:0];
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpp_q      <= MPP_RST;
      ascale_q   <= ASCALE_RST;
      thr_q      <= THR_RST;
      start_x_q  <= '0;
      start_y_q  <= '0;
      start_hd_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_MPP:       mpp_q      <= cfg_data_i;
        REG_ASCALE:    ascale_q   <= cfg_data_i;
        REG_THRESHOLD: thr_q      <= cfg_data_i[30:0];
        REG_START_X:   start_x_q  <= cfg_data_i;
        REG_START_Y:   start_y_q  <= cfg_data_i;
        REG_START_HD:  start_hd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= {dist_q, hd_q, y_q, x_q};
    end
  end

  // sequencer and odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_DL;
      prev_l_q <= '0;
      prev_r_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      hd_q     <= '0;
      dist_q   <= '0;
      half_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prev_l_q <= s_axis_tdata[31:0];
            prev_r_q <= s_axis_tdata[63:32];
            if (s_axis_tuser) begin
              x_q     <= start_x_q;
              y_q     <= start_y_q;
              hd_q    <= start_hd_q;
              dist_q  <= '0;
              state_q <= S_DONE;
            end else begin
              op_q    <= OP_DL;
              state_q <= S_PREP;
            end
          end
        end
        S_PREP:  state_q <= S_MLO;
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_MFIN;
        S_MFIN: begin
          unique case (op_q)
            OP_DL: begin op_q <= OP_DR; state_q <= S_PREP; end
            OP_DR: begin op_q <= OP_DT; state_q <= S_PREP; end
            OP_DT: begin
              // arc path needs sinc from the half-angle CORDIC and a divide
              half_q  <= !(dt_mag < thr_q) && (dt_mag != '0);
              state_q <= S_CINIT;
            end
            OP_C:  begin op_q <= OP_S;  state_q <= S_PREP; end
            OP_S:  begin op_q <= OP_PX; state_q <= S_PREP; end
            OP_PX: begin
              x_q     <= x_sat;
              op_q    <= OP_PY;
              state_q <= S_PREP;
            end
            OP_PY: begin
              y_q     <= y_sat;
              hd_q    <= hd_q + dt_q;
              dist_q  <= d_sat;
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_CINIT: state_q <= S_CITER;
        S_CITER: begin
          if (ci_q == CrdLast) state_q <= S_CDONE;
        end
        S_CDONE: begin
          if (half_q) begin
            state_q <= S_NUM;
          end else begin
            op_q    <= OP_C;
            state_q <= S_PREP;
          end
        end
        S_NUM:   state_q <= S_DINIT;
        S_DINIT: state_q <= S_DITER;
        S_DITER: begin
          if (dcnt_q == 6'd63) state_q <= S_DFIN;
        end
        S_DFIN: begin
          half_q  <= 1'b0;
          state_q <= S_CINIT;
        end
        S_DONE: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        dlt_l_q <= s_axis_tdata[31:0] - prev_l_q;
        dlt_r_q <= s_axis_tdata[63:32] - prev_r_q;
      end
      S_PREP: begin
        unique case (op_q)
          OP_DL: begin
            a_q <= 45'(abs_dlt_l); b_q <= mpp_q; neg_q <= dlt_l_q[31]; sh_q <= 5'd20;
          end
          OP_DR: begin
            a_q <= 45'(abs_dlt_r); b_q <= mpp_q; neg_q <= dlt_r_q[31]; sh_q <= 5'd20;
          end
          OP_DT: begin
            a_q      <= abs_diff;
            b_q      <= ascale_q;
            neg_q    <= diff[45];
            sh_q     <= 5'd16;
            centre_q <= csum[45:1];
          end
          OP_C: begin
            a_q <= 45'(abs_c); b_q <= {1'b0, sinc_q}; neg_q <= c_q[33]; sh_q <= 5'd30;
          end
          OP_S: begin
            a_q <= 45'(abs_s); b_q <= {1'b0, sinc_q}; neg_q <= s_q[33]; sh_q <= 5'd30;
          end
          OP_PX: begin
            a_q   <= abs_centre;
            b_q   <= abs_c2;
            neg_q <= centre_q[44] ^ c2_q[33];
            sh_q  <= 5'd30;
          end
          OP_PY: begin
            a_q   <= abs_centre;
            b_q   <= abs_s2;
            neg_q <= centre_q[44] ^ s2_q[33];
            sh_q  <= 5'd30;
          end
          default: ;
        endcase
      end
      S_MLO: prod_q <= mul_p;
      S_MHI: begin
        acc_q  <= lo_part;
        prod_q <= mul_p;
      end
      S_MFIN: begin
        unique case (op_q)
          OP_DL: dl_q <= $signed(res[44:0]);
          OP_DR: dr_q <= $signed(res[44:0]);
          OP_DT: begin
            dt_q   <= dt_val;
            adt_q  <= dt_mag;
            sinc_q <= ONE_Q30;
            if (dt_mag < thr_q) ang_q <= hd_q;
            else                ang_q <= hd_q + (dt_val >>> 1);
          end
          OP_C:  c2_q <= $signed(res[33:0]);
          OP_S:  s2_q <= $signed(res[33:0]);
          default: ;
        endcase
      end
      S_CINIT: begin
        cx_q   <= $signed(CORDIC_GAIN_INV);
        cy_q   <= '0;
        cz_q   <= crd_zw;
        flip_q <= crd_wrap;
        ci_q   <= '0;
      end
      S_CITER: begin
        if (cz_q >= 0) begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
          cz_q <= cz_q - catan;
        end else begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
          cz_q <= cz_q + catan;
        end
        ci_q <= ci_q + 5'd1;
      end
      S_CDONE: begin
        if (half_q) begin
          // negative half-angle sine clamps to zero
          a_q <= fy[33] ? '0 : 45'(fy[31:0]);
          b_q <= TWO32_OVER_PI;
        end else begin
          c_q <= fx;
          s_q <= fy;
        end
      end
      S_NUM:   prod_q <= mul_p;
      S_DINIT: begin
        quo_q  <= prod_q;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      S_DITER: begin
        rem_q  <= div_ge ? rem_sub[31:0] : rem_ext[31:0];
        quo_q  <= {quo_q[62:0], div_ge};
        dcnt_q <= dcnt_q + 6'd1;
      end
      S_DFIN: begin
        sinc_q <= (quo_q > 64'(ONE_Q30)) ? ONE_Q30 : quo_q[30:0];
      end
      default: ;
    endcase
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import ddo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE      = 200;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 163;

  typedef struct packed {
    logic [47:0] travel;
    logic [31:0] hdg;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] a;       // cfg data or left count
    logic [31:0] b;       // right count
    logic        rb;
    logic        typed;   // expected pose written out below
    logic [31:0] ex, ey, eh;
    logic [47:0] ed;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;

  differential_drive_odometry dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // odometry state mirrored in the bench
  logic [31:0] mpp, ascale, sx0, sy0, sh0;
  logic [30:0] thr;
  logic [31:0] last_l, last_r, acc_x, acc_y, acc_h;
  longint      acc_d;

  pose_t pose_q[$];
  int    errors = 0;
  int    n_items = 0, n_results = 0, n_rebase = 0, n_arc = 0, n_cfg = 0;
  int    cycles = 0;
  bit    no_stall = 1'b0;

  const logic [31:0] atan_rom[32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  // signed (a*b) >> s, rounded half away from zero on the magnitude
  function automatic longint mul_round(longint a, longint b, int s);
    logic        neg;
    logic [63:0] ma, mb;
    logic [127:0] p;
    longint      r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = ({64'd0, ma} * {64'd0, mb}) + (128'd1 << (s - 1));
    r   = longint'(p >> s);
    return neg ? -r : r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic        flip;
    longint      z, x, y, dx, dy;
    a    = ang & (32'hFFFF_FFFF << (32 - ANGLE_BITS_DEF));
    flip = 1'b0;
    x    = longint'(CORDIC_GAIN_INV);
    y    = 0;
    z    = longint'($signed(a));
    // outside +-quarter turn: rotate by a half turn, negate afterwards
    if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
      a    = a + 32'h8000_0000;
      z    = longint'($signed(a));
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_rom[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_rom[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(logic [31:0] lc, logic [31:0] rc, logic rb);
    logic [31:0] dcl, dcr, ang;
    longint      dl, dr, centre, dt, adt, sinc, c, s, hc, hs;
    pose_t       p;
    if (rb) begin
      acc_x = sx0; acc_y = sy0; acc_h = sh0; acc_d = 0;
    end else begin
      dcl    = lc - last_l;
      dcr    = rc - last_r;
      dl     = mul_round(longint'($signed(dcl)), longint'(mpp), 20);
      dr     = mul_round(longint'($signed(dcr)), longint'(mpp), 20);
      centre = (dl + dr) >>> 1;
      dt     = clip(mul_round(dr - dl, longint'(ascale), 16),
                    -64'sd2147483647, 64'sd2147483647);
      adt    = (dt < 0) ? -dt : dt;
      sinc   = 64'sd1073741824;
      ang    = acc_h;
      if (!(adt < longint'(thr))) begin
        n_arc++;
        ang = acc_h + 32'(dt >>> 1);
        if (adt != 0) begin
          rotate(32'(adt >> 1), hc, hs);
          if (hs < 0) hs = 0;
          sinc = longint'((64'(hs) * 64'(TWO32_OVER_PI)) / 64'(adt));
          if (sinc > 64'sd1073741824) sinc = 64'sd1073741824;
        end
      end
      rotate(ang, c, s);
      c = mul_round(c, sinc, 30);
      s = mul_round(s, sinc, 30);
      acc_x = 32'(clip(longint'($signed(acc_x)) + mul_round(centre, c, 30),
                       -64'sd2147483648, 64'sd2147483647));
      acc_y = 32'(clip(longint'($signed(acc_y)) + mul_round(centre, s, 30),
                       -64'sd2147483648, 64'sd2147483647));
      acc_h = acc_h + 32'(dt);
      acc_d = clip(acc_d + centre, -64'sd140737488355328, 64'sd140737488355327);
    end
    last_l = lc;
    last_r = rc;
    p.x = acc_x; p.y = acc_y; p.hdg = acc_h; p.travel = 48'(acc_d);
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
    $display("mismatch result %0d %s: got %h expected %h", n_results, field, got, want);
    errors++;
  endtask

  // result side: compare on transfer, then pick the next stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    pose_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("differential_drive_odometry verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pose_q.size() == 0) begin
        $display("result with no sample outstanding: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.x !== want.x) report_mismatch("pos_x", 48'(got.x), 48'(want.x));
        if (got.y !== want.y) report_mismatch("pos_y", 48'(got.y), 48'(want.y));
        if (got.hdg !== want.hdg) report_mismatch("heading", 48'(got.hdg), 48'(want.hdg));
        if (got.travel !== want.travel) report_mismatch("distance", got.travel, want.travel);
      end
      n_results++;
    end
    if (no_stall) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  // one sample transfer; tvalid only drops when a gap is taken
  task automatic send_sample(logic [31:0] lc, logic [31:0] rc, logic rb,
                             logic typed = 1'b0, pose_t want = '0);
    int    gap;
    pose_t p;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rc, lc};
    s_axis_tuser  <= rb;
    do @(posedge clk_i); while (!s_axis_tready);
    p = advance_pose(lc, rc, rb);
    pose_q.push_back(typed ? want : p);
    n_items++;
    if (rb) n_rebase++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      REG_MPP:       mpp = val;
      REG_ASCALE:    ascale = val;
      REG_THRESHOLD: thr = val[30:0];
      REG_START_X:   sx0 = val;
      REG_START_Y:   sy0 = val;
      REG_START_HD:  sh0 = val;
      default: ;     // unknown index, no effect
    endcase
    @(posedge clk_i);
  endtask

  // Directed rows: reset pose, saturated turns, start-pose extremes with a
  // saturating position, zero and full threshold, register extremes and
  // writes to unused indexes.
  row_t dir_rows[] = '{
    '{ROW_SAMPLE, 3'd0, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 48'h0},
    '{ROW_SAMPLE, 3'd0, 32'd100, 32'd100, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'd150, 32'd90, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_START_X, 32'h7FFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_START_Y, 32'h8000_0000, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_START_HD, 32'h8000_0000, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'd5, 32'd7, 1'b1, 1'b1,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 48'h0},
    '{ROW_SAMPLE, 3'd0, 32'hC000_0005, 32'hC000_0007, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_THRESHOLD, 32'h0, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'hC000_0005, 32'hC000_0007, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'hC000_1005, 32'hBFFF_0007, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_THRESHOLD, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 32'h1000, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MPP, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_ASCALE, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'h1234, 32'h9876_5432, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, 3'd6, 32'hDEAD_BEEF, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, 3'd7, 32'h1234_5678, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MPP, 32'd1, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_ASCALE, 32'd1, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_CFG, REG_THRESHOLD, 32'h0, 0, 1'b0, 1'b0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 3'd0, 32'h7000_0000, 32'h1000_0000, 1'b0, 1'b0, 0, 0, 0, 0}
  };

  function automatic logic [31:0] pick_reg(int phase, logic [31:0] dflt, logic [31:0] lo,
                                           logic [31:0] hi);
    int r;
    if (phase == 1) return hi;
    if (phase == 2) return lo;
    r = $urandom_range(0, 9);
    if (r < 4) return dflt;
    if (r < 5) return lo;
    if (r < 6) return hi;
    if (r < 8) return $urandom_range(lo, dflt > 32'd1 ? 2 * (dflt / 2) : 32'd64);
    return $urandom_range(lo, hi);
  endfunction

  initial begin
    pose_t       want;
    logic [31:0] lc, rc;
    int          r, burst;

    mpp = MPP_RST; ascale = ASCALE_RST; thr = THR_RST;
    sx0 = '0; sy0 = '0; sh0 = '0;
    last_l = '0; last_r = '0; acc_x = '0; acc_y = '0; acc_h = '0; acc_d = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].a);
      end else begin
        want = '{travel: dir_rows[i].ed, hdg: dir_rows[i].eh,
                 y: dir_rows[i].ey, x: dir_rows[i].ex};
        send_sample(dir_rows[i].a, dir_rows[i].b, dir_rows[i].rb, dir_rows[i].typed, want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      no_stall = (ph % 4 == 3);
      write_reg(REG_MPP, pick_reg(ph, MPP_RST, 32'd1, 32'hFFFF_FFFF));
      write_reg(REG_ASCALE, pick_reg(ph, ASCALE_RST, 32'd1, 32'hFFFF_FFFF));
      write_reg(REG_THRESHOLD, pick_reg(ph, 32'(THR_RST), 32'd0, 32'h7FFF_FFFF));
      write_reg(REG_START_X, (ph == 1) ? 32'h7FFF_FFFF : (ph == 2) ? 32'h8000_0000 : $urandom);
      write_reg(REG_START_Y, (ph == 1) ? 32'h7FFF_FFFF : (ph == 2) ? 32'h8000_0000 : $urandom);
      write_reg(REG_START_HD, (ph == 1) ? 32'h7FFF_FFFF : (ph == 2) ? 32'h8000_0000 : $urandom);
      send_sample($urandom, $urandom, 1'b1);
      burst = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == 80) drain();   // hold off until the block is empty
        r = $urandom_range(0, 99);
        if (burst > 0) begin
          // both wheels at the largest forward step: drives distance and pose to limits
          burst--;
          lc = last_l + 32'h7FFF_FFFF;
          rc = last_r + 32'h7FFF_FFFF - $urandom_range(0, 3);
          send_sample(lc, rc, 1'b0);
        end else if (r < 3) begin
          send_sample($urandom, $urandom, 1'b1);
        end else if (r < 9) begin
          send_sample($urandom, $urandom, 1'b0);
        end else if (r < 11) begin
          burst = 20;
        end else begin
          lc = last_l + 32'($urandom_range(0, 2000)) - 32'd1000;
          rc = (r < 30) ? last_r + (lc - last_l)
                        : last_r + 32'($urandom_range(0, 2000)) - 32'd1000;
          send_sample(lc, rc, 1'b0);
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d samples (%0d rebase, %0d on the arc path), %0d results, %0d register writes",
             n_items, n_rebase, n_arc, n_results, n_cfg);
    $display("register extremes, saturation bursts and random back-pressure exercised");
    if (errors == 0) begin
      $display("differential_drive_odometry verification clean");
    end else begin
      $display("differential_drive_odometry verification failed");
    end
    $finish;
  end

endmodule
